// File: hw/rtl/tvsg_pkg.sv
package tvsg_pkg;

	// operation codes
	localparam logic [2:0] OP_SPLAT_DENSITY  = 3'd0;
	localparam logic [2:0] OP_SPLAT_VELOCITY = 3'd1;
	localparam logic [2:0] OP_QUERY_DENSITY  = 3'd2;
	localparam logic [2:0] OP_QUERY_VELOCITY = 3'd3;
	localparam logic [2:0] OP_CLEAR          = 3'd4;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Z       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_VOXEL_SIZE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_POINTS    = 3'd4;

	localparam logic [31:0] INV_VOXEL_SIZE_RESET = 32'h0001_0000;
	localparam logic [4:0]  GRID_POINTS_RESET    = 5'd16;

	localparam int MAX_POINTS_PER_AXIS = 16;
	localparam int FRACTION_BITS       = 16;

endpackage

// File: hw/rtl/tvsg_ram.sv
module tvsg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/trilinear_voxel_splat_grid.sv
// Trilinear voxel splat grid: a cubic grid of density and velocity samples held in four
// single-port-write, registered-read memories (one per component). An item splats a value over
// the eight corners of the cell around a position, queries the trilinear-interpolated value
// there (one result transfer), or clears the grid. Each item runs alone: it is accepted, the
// locate steps (LOC1, LOC2) find cell and fraction per axis, the corner step walks the eight
// corners (one memory read per corner, writes trail behind through pipe registers s1, s2 and
// s3), the drain step empties the read-modify-write pipe and, for a query, a final step rounds
// and loads the result register, held off while an earlier result still waits on out_stall. An
// unused operation code is only accepted. After reset and after a clear the grid is swept to
// zero one entry per cycle, all MAX_POINTS_PER_AXIS cubed entries (4096 by default), while
// in_stall stays high.
// Configuration writes may be done at any time the block holds no item.
module trilinear_voxel_splat_grid #(
	parameter int MAX_POINTS_PER_AXIS = tvsg_pkg::MAX_POINTS_PER_AXIS,
	parameter int FRACTION_BITS       = tvsg_pkg::FRACTION_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input item channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [2:0]                       operation,
	input  logic signed [31:0]               pos_x,
	input  logic signed [31:0]               pos_y,
	input  logic signed [31:0]               pos_z,
	input  logic signed [31:0]               value_x,
	input  logic signed [31:0]               value_y,
	input  logic signed [31:0]               value_z,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [31:0]               result_x,
	output logic signed [31:0]               result_y,
	output logic signed [31:0]               result_z,
	output logic                             saturated,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [tvsg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);

	localparam int M     = MAX_POINTS_PER_AXIS;
	localparam int FB    = FRACTION_BITS;
	localparam int DEPTH = M * M * M;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(M);
	localparam int WW    = FB + 1;        // weight, 1.0 = 2^FB
	localparam int PW    = FB + 34;       // weight times sample
	localparam int SW    = PW + 3;        // sum over eight corners

	localparam logic [WW-1:0]       ONE   = WW'(1) << FB;
	localparam logic [2*WW-1:0]     HALFW = (2*WW)'(1) << (FB - 1);
	localparam logic signed [SW-1:0] HALF = SW'(1) << (FB - 1);
	localparam logic signed [SW-1:0] MAXV = {{(SW-32){1'b0}}, 32'h7fff_ffff};
	localparam logic signed [SW-1:0] MINV = {{(SW-32){1'b1}}, 32'h8000_0000};

	// sequencer codes
	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_LOC1   = 3'd2;
	localparam logic [2:0] ST_LOC2   = 3'd3;
	localparam logic [2:0] ST_CORNER = 3'd4;
	localparam logic [2:0] ST_DRAIN  = 3'd5;
	localparam logic [2:0] ST_FINAL  = 3'd6;

	// clip to 32 bits, top bit flags a clip
	function automatic logic [32:0] sat_fn(input logic signed [SW-1:0] x);
		logic [32:0] r;
		if (x > MAXV) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (x < MINV) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, x[31:0]};
		end
		return r;
	endfunction

	// configuration
	logic signed [31:0] org_q [3];
	logic [31:0]        inv_q;
	logic [4:0]         gp_q;

	// sequencer and item
	logic [2:0]         state_q;
	logic [AW-1:0]      clr_cnt_q;
	logic [2:0]         corner_q;
	logic [2:0]         op_q;
	logic signed [31:0] pos_q [3];
	logic signed [31:0] val_q [3];
	logic               clip_q;

	// cell location per axis
	logic               neg_q [3];
	logic [47:0]        a_q   [3];
	logic [47:0]        b_q   [3];
	logic [CW-1:0]      cell_q [3];
	logic [WW-1:0]      frac_q [3];

	// corner pipeline
	logic               vld_s1, vld_s2, vld_s3;
	logic [WW-1:0]      wxy_s1, wz_s1, w_s2;
	logic [AW-1:0]      addr_s1, addr_s2, addr_s3;
	logic signed [31:0] data_s2 [3];
	logic signed [31:0] old_s3  [3];
	logic signed [PW-1:0] prod_s3 [3];
	logic signed [SW-1:0] acc_q [3];

	// result register
	logic               out_valid_q;
	logic signed [31:0] res_q [3];
	logic               sat_q;

	logic is_splat, is_query, is_density;
	logic [2:0] lane_en;

	assign is_splat   = (op_q == tvsg_pkg::OP_SPLAT_DENSITY) ||
	                    (op_q == tvsg_pkg::OP_SPLAT_VELOCITY);
	assign is_query   = (op_q == tvsg_pkg::OP_QUERY_DENSITY) ||
	                    (op_q == tvsg_pkg::OP_QUERY_VELOCITY);
	assign is_density = (op_q == tvsg_pkg::OP_SPLAT_DENSITY) ||
	                    (op_q == tvsg_pkg::OP_QUERY_DENSITY);
	assign lane_en    = is_density ? 3'b001 : 3'b111;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			inv_q    <= tvsg_pkg::INV_VOXEL_SIZE_RESET;
			gp_q     <= tvsg_pkg::GRID_POINTS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tvsg_pkg::REG_ORIGIN_X:       org_q[0] <= cfg_data;
				tvsg_pkg::REG_ORIGIN_Y:       org_q[1] <= cfg_data;
				tvsg_pkg::REG_ORIGIN_Z:       org_q[2] <= cfg_data;
				tvsg_pkg::REG_INV_VOXEL_SIZE: inv_q    <= cfg_data;
				tvsg_pkg::REG_GRID_POINTS:    gp_q     <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// stage 1 of locate: offset from origin times the reciprocal, in two halves
	logic [32:0] d_w [3];
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			d_w[a] = {pos_q[a][31], pos_q[a]} - {org_q[a][31], org_q[a]};
		end
	end

	// stage 2 of locate: cell and fraction with range clamps
	logic [31:0]   pts_w, last_w;
	logic [63:0]   p_w   [3];
	logic [CW-1:0] cell_w [3];
	logic [WW-1:0] frac_w [3];
	always_comb begin
		if (gp_q < 5'd2) begin
			pts_w = 32'd2;
		end else if (32'(gp_q) > 32'(M)) begin
			pts_w = 32'(M);
		end else begin
			pts_w = 32'(gp_q);
		end
		last_w = pts_w - 32'd1;
		for (int a = 0; a < 3; a++) begin
			p_w[a] = {a_q[a], 16'b0} + 64'(b_q[a]);
			if (neg_q[a]) begin
				cell_w[a] = '0;
				frac_w[a] = '0;
			end else if (p_w[a][63:32] >= last_w) begin
				cell_w[a] = CW'(last_w - 32'd1);
				frac_w[a] = ONE;
			end else begin
				cell_w[a] = p_w[a][32+CW-1:32];
				frac_w[a] = WW'(p_w[a][31:32-FB]);
			end
		end
	end

	// corner issue: address and first weight product, plus the second weight product of stage 1
	logic [WW-1:0]   wsel [3];
	logic [2*WW-1:0] wxy_full, wz_full;
	logic [AW-1:0]   ii, jj, kk, rd_addr;
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			wsel[a] = corner_q[a] ? frac_q[a] : ONE - frac_q[a];
		end
		wxy_full = (2*WW)'(wsel[0]) * (2*WW)'(wsel[1]) + HALFW;
		ii = AW'(cell_q[0]) + AW'(corner_q[0]);
		jj = AW'(cell_q[1]) + AW'(corner_q[1]);
		kk = AW'(cell_q[2]) + AW'(corner_q[2]);
		rd_addr = kk * AW'(M * M) + jj * AW'(M) + ii;
		wz_full = (2*WW)'(wxy_s1) * (2*WW)'(wz_s1) + HALFW;
	end

	// memories
	logic               ram_we [4];
	logic [AW-1:0]      ram_waddr;
	logic [31:0]        ram_wdata [4];
	logic [31:0]        ram_rdata [4];
	logic signed [31:0] lane_rd [3];

	for (genvar g = 0; g < 4; g++) begin : g_store
		tvsg_ram #(
			.WIDTH(32),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[g]),
			.waddr(ram_waddr),
			.wdata(ram_wdata[g]),
			.raddr(rd_addr),
			.rdata(ram_rdata[g])
		);
	end

	// store 0 density, stores 1..3 velocity x, y, z
	assign lane_rd[0] = is_density ? ram_rdata[0] : ram_rdata[1];
	assign lane_rd[1] = ram_rdata[2];
	assign lane_rd[2] = ram_rdata[3];

	// write-back: rounded add and clip
	logic signed [SW-1:0] add_w [3];
	logic [32:0]          new_w [3];
	logic                 splat_clip;
	always_comb begin
		splat_clip = 1'b0;
		for (int l = 0; l < 3; l++) begin
			add_w[l] = (SW'(prod_s3[l]) + HALF) >>> FB;
			new_w[l] = sat_fn(add_w[l] + SW'(old_s3[l]));
			if (vld_s3 && is_splat && lane_en[l] && new_w[l][32]) begin
				splat_clip = 1'b1;
			end
		end
	end

	always_comb begin
		ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : addr_s3;
		ram_wdata[0] = (state_q == ST_CLEAR) ? 32'd0 : new_w[0][31:0];
		ram_wdata[1] = (state_q == ST_CLEAR) ? 32'd0 : new_w[0][31:0];
		ram_wdata[2] = (state_q == ST_CLEAR) ? 32'd0 : new_w[1][31:0];
		ram_wdata[3] = (state_q == ST_CLEAR) ? 32'd0 : new_w[2][31:0];
		ram_we[0] = (state_q == ST_CLEAR) ||
		            (vld_s3 && op_q == tvsg_pkg::OP_SPLAT_DENSITY);
		ram_we[1] = (state_q == ST_CLEAR) ||
		            (vld_s3 && op_q == tvsg_pkg::OP_SPLAT_VELOCITY);
		ram_we[2] = ram_we[1];
		ram_we[3] = ram_we[1];
	end

	// query finish: round and clip the sums
	logic [32:0] fin_w [3];
	logic        fin_clip, out_fire;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			fin_w[l] = sat_fn((acc_q[l] + HALF) >>> FB);
		end
		fin_clip = fin_w[0][32] || (lane_en[1] && (fin_w[1][32] || fin_w[2][32]));
		out_fire = (state_q == ST_FINAL) && (!out_valid_q || !out_stall);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			corner_q  <= '0;
			clip_q    <= 1'b0;
			op_q      <= tvsg_pkg::OP_SPLAT_DENSITY;
		end else begin
			if (splat_clip) begin
				clip_q <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q <= operation;
						case (operation)
							tvsg_pkg::OP_CLEAR: begin
								state_q   <= ST_CLEAR;
								clr_cnt_q <= '0;
								clip_q    <= 1'b0;
							end
							tvsg_pkg::OP_SPLAT_DENSITY, tvsg_pkg::OP_SPLAT_VELOCITY,
							tvsg_pkg::OP_QUERY_DENSITY, tvsg_pkg::OP_QUERY_VELOCITY: begin
								state_q <= ST_LOC1;
							end
							default: ;
						endcase
					end
				end
				ST_LOC1: state_q <= ST_LOC2;
				ST_LOC2: begin
					state_q  <= ST_CORNER;
					corner_q <= '0;
				end
				ST_CORNER: begin
					corner_q <= corner_q + 3'd1;
					if (corner_q == 3'd7) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2 && !vld_s3) begin
						state_q <= is_query ? ST_FINAL : ST_IDLE;
					end
				end
				ST_FINAL: begin
					if (out_fire) begin
						state_q <= ST_IDLE;
						clip_q  <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture, locate stages, sum registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			val_q[0] <= value_x;
			val_q[1] <= value_y;
			val_q[2] <= value_z;
		end
		for (int a = 0; a < 3; a++) begin
			if (state_q == ST_LOC1) begin
				neg_q[a] <= d_w[a][32];
				a_q[a]   <= 48'(d_w[a][31:0]) * 48'(inv_q[31:16]);
				b_q[a]   <= 48'(d_w[a][31:0]) * 48'(inv_q[15:0]);
				acc_q[a] <= '0;
			end
			if (state_q == ST_LOC2) begin
				cell_q[a] <= cell_w[a];
				frac_q[a] <= frac_w[a];
			end
			if (vld_s3 && is_query) begin
				acc_q[a] <= acc_q[a] + SW'(prod_s3[a]);
			end
		end
	end

	// corner pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_CORNER);
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// corner pipeline payload
	always_ff @(posedge clk) begin
		wxy_s1  <= wxy_full[FB +: WW];
		wz_s1   <= wsel[2];
		addr_s1 <= rd_addr;
		w_s2    <= wz_full[FB +: WW];
		addr_s2 <= addr_s1;
		addr_s3 <= addr_s2;
		for (int l = 0; l < 3; l++) begin
			data_s2[l] <= lane_rd[l];
			old_s3[l]  <= data_s2[l];
			prod_s3[l] <= PW'($signed({1'b0, w_s2})) *
			              PW'(is_splat ? val_q[l] : data_s2[l]);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			res_q[0] <= fin_w[0][31:0];
			res_q[1] <= lane_en[1] ? fin_w[1][31:0] : 32'd0;
			res_q[2] <= lane_en[2] ? fin_w[2][31:0] : 32'd0;
			sat_q    <= clip_q || fin_clip;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign result_x  = res_q[0];
	assign result_y  = res_q[1];
	assign result_z  = res_q[2];
	assign saturated = sat_q;

	// during the corner walk a write-back never lands on the entry being read in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && state_q == ST_CORNER) |-> (addr_s3 != rd_addr))
		else $error("write-back collides with corner read");

	// no store write while the block waits for an item
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(ram_we[0] || ram_we[1]))
		else $error("store written while idle");

	// a new result comes only from a query's finish step
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINAL &&
		($past(op_q) == tvsg_pkg::OP_QUERY_DENSITY ||
		 $past(op_q) == tvsg_pkg::OP_QUERY_VELOCITY)))
		else $error("result without a query");

	// the pipe is empty whenever the next item may be taken
	a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !(vld_s1 || vld_s2 || vld_s3))
		else $error("corner pipe busy while idle");

endmodule
